>>> rtl/mecanum_wheel_speed_limiter_defines.svh
// Assertion macros used by the top level of the mecanum wheel speed limiter RTL.
`ifndef MECANUM_WHEEL_SPEED_LIMITER_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_LIMITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MWS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MWS_ASSERT(lbl, prop, msg)
`define MWS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/mws_pkg.sv
// Types and constants of the mecanum wheel speed limiter.
package mws_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LIM_W      = 15;
  localparam int CNT_W      = 16;
  localparam int NUM_WHEELS = 4;
  localparam int WIDX_W     = 2;

  localparam int SUM_W  = 18;
  localparam int AWP_W  = 33;
  localparam int WP_W   = 35;
  localparam int WHL_W  = 24;
  localparam int MAG_W  = 22;
  localparam int QUO_W  = 15;
  localparam int DVD_W  = MAG_W + LIM_W;
  localparam int STEP_W = 4;

  localparam logic [CFG_W-1:0] INV_RADIUS_RST = 16'd3368;
  localparam logic [CFG_W-1:0] ARM_SUM_RST    = 16'd26214;
  localparam logic [LIM_W-1:0] MAX_SPEED_RST  = 15'd5120;
  localparam logic [CNT_W-1:0] WD_TIMEOUT_RST = 16'd500;

  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RADIUS = 2'd0,
    REG_ARM_SUM    = 2'd1,
    REG_MAX_SPEED  = 2'd2,
    REG_WD_TIMEOUT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              in_ready;
    logic              load_in;
    logic              calc_aw;
    logic              calc_sum;
    logic              calc_wheel;
    logic              calc_max;
    logic              scale_prep;
    logic              div_init;
    logic              div_step;
    logic              commit_plain;
    logic              commit_scaled;
    logic              tick_update;
    logic              out_load;
    logic [WIDX_W-1:0] lane;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic need_scale;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/mws_if.sv
// Handshake channel interfaces of the mecanum wheel speed limiter.
interface mws_in_if import mws_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic signed [IN_W-1:0] vel_x;
  logic signed [IN_W-1:0] vel_y;
  logic signed [IN_W-1:0] yaw_rate;

  modport source (output valid, output cmd, output vel_x, output vel_y, output yaw_rate,
                  input ready);
  modport sink (input valid, input cmd, input vel_x, input vel_y, input yaw_rate,
                output ready);
endinterface

interface mws_out_if import mws_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] wheel0_speed;
  logic signed [OUT_W-1:0] wheel1_speed;
  logic signed [OUT_W-1:0] wheel2_speed;
  logic signed [OUT_W-1:0] wheel3_speed;
  logic                    timed_out;

  modport source (output valid, output wheel0_speed, output wheel1_speed,
                  output wheel2_speed, output wheel3_speed, output timed_out, input ready);
  modport sink (input valid, input wheel0_speed, input wheel1_speed,
                input wheel2_speed, input wheel3_speed, input timed_out, output ready);
endinterface

interface mws_cfg_if import mws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

>>> rtl/mecanum_wheel_speed_limiter.sv
// Top level of the mecanum wheel speed limiter.
// The block handles one beat at a time. A tick beat passes through the tick update
// state and then the output state. A velocity command runs the kinematics states and,
// when a wheel exceeds the limit, the scaling states: one shared multiplier forms the
// four wheel products one per cycle, and the limiter runs four restoring divider lanes
// with a common divisor for fifteen steps. The next beat is accepted in the cycle after
// the result is placed in the output register, which holds it until the sink takes it.
`include "mecanum_wheel_speed_limiter_defines.svh"

module mecanum_wheel_speed_limiter import mws_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mws_cfg_if.sink   cfg_i,
  mws_in_if.sink    in_i,
  mws_out_if.source out_o
);

  ctrl_cmd_t  ctl_cmd;
  dp_status_t dp_status;

  mws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (dp_status),
    .cmd_o    (ctl_cmd)
  );

  mws_datapath #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (ctl_cmd),
    .status_o (dp_status)
  );

  `MWS_ASSERT(a_one_beat_in_flight, (in_i.valid && in_i.ready) |=> !in_i.ready, "second beat accepted while busy")
  `MWS_ASSERT_NEVER(a_load_into_full_slot, ctl_cmd.out_load && out_o.valid && !out_o.ready, "result overwritten")
  `MWS_ASSERT(a_timeout_zeroes, (out_o.valid && out_o.timed_out) |-> (out_o.wheel0_speed == '0 && out_o.wheel1_speed == '0 && out_o.wheel2_speed == '0 && out_o.wheel3_speed == '0), "timeout with nonzero setpoint")
  `MWS_ASSERT(a_single_commit, $onehot0({ctl_cmd.commit_plain, ctl_cmd.commit_scaled, ctl_cmd.tick_update, ctl_cmd.out_load}), "conflicting datapath commands")

endmodule

>>> rtl/mws_ctrl.sv
// Sequencing state machine of the mecanum wheel speed limiter.
module mws_ctrl import mws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AW    = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_WHEEL = 4'd3;
  localparam logic [3:0] S_MAX   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_PREP  = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_CSCL  = 4'd9;
  localparam logic [3:0] S_TICK  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [WIDX_W-1:0] LANE_LAST = WIDX_W'(NUM_WHEELS - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  logic [3:0]        state_q, state_d;
  logic [WIDX_W-1:0] lane_q, lane_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    lane_d  = lane_q;
    step_d  = step_q;
    cmd_o.lane = lane_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.load_in = 1'b1;
          state_d = status_i.in_tick ? S_TICK : S_AW;
        end
      end
      S_AW: begin
        cmd_o.calc_aw = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.calc_sum = 1'b1;
        lane_d  = '0;
        state_d = S_WHEEL;
      end
      S_WHEEL: begin
        cmd_o.calc_wheel = 1'b1;
        lane_d = lane_q + 1'b1;
        if (lane_q == LANE_LAST) begin
          state_d = S_MAX;
        end
      end
      S_MAX: begin
        cmd_o.calc_max = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.need_scale) begin
          lane_d  = '0;
          state_d = S_PREP;
        end else begin
          cmd_o.commit_plain = 1'b1;
          state_d = S_OUT;
        end
      end
      S_PREP: begin
        cmd_o.scale_prep = 1'b1;
        lane_d = lane_q + 1'b1;
        if (lane_q == LANE_LAST) begin
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = S_CSCL;
        end
      end
      S_CSCL: begin
        cmd_o.commit_scaled = 1'b1;
        state_d = S_OUT;
      end
      S_TICK: begin
        cmd_o.tick_update = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> rtl/mws_datapath.sv
// Datapath of the mecanum wheel speed limiter: registers, kinematics, limiter and watchdog.
module mws_datapath import mws_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mws_cfg_if.sink    cfg_i,
  mws_in_if.sink     in_i,
  mws_out_if.source  out_o,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o
);

  localparam int SMAX = (SPEED_WIDTH >= 16) ? 32767 : ((2 ** (SPEED_WIDTH - 1)) - 1);
  localparam logic signed [WHL_W-1:0] SMAX_W = WHL_W'(SMAX);
  localparam logic signed [AWP_W:0]   RND16  = (AWP_W + 1)'(32768);
  localparam logic signed [WP_W:0]    RND12  = (WP_W + 1)'(2048);
  localparam logic [CNT_W-1:0]        CNT_MAX = '1;

  function automatic logic signed [SPEED_WIDTH-1:0] sat_speed(input logic signed [WHL_W-1:0] v);
    logic signed [WHL_W-1:0] c;
    if (v > SMAX_W) begin
      c = SMAX_W;
    end else if (v < -SMAX_W) begin
      c = -SMAX_W;
    end else begin
      c = v;
    end
    return SPEED_WIDTH'(c);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] inv_r_q, arm_q;
  logic [LIM_W-1:0] lim_q;
  logic [CNT_W-1:0] tmo_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_r_q <= INV_RADIUS_RST;
      arm_q   <= ARM_SUM_RST;
      lim_q   <= MAX_SPEED_RST;
      tmo_q   <= WD_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.idx))
        REG_INV_RADIUS: inv_r_q <= cfg_i.data;
        REG_ARM_SUM:    arm_q   <= cfg_i.data;
        REG_MAX_SPEED:  lim_q   <= cfg_i.data[LIM_W-1:0];
        REG_WD_TIMEOUT: tmo_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input beat capture.
  logic signed [IN_W-1:0] vx_q, vy_q, vw_q;

  assign in_i.ready        = cmd_i.in_ready;
  assign status_o.in_valid = in_i.valid;
  assign status_o.in_tick  = (in_i.cmd == CMD_TICK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vx_q <= in_i.vel_x;
      vy_q <= in_i.vel_y;
      vw_q <= in_i.yaw_rate;
    end
  end

  // Kinematics.
  logic signed [AWP_W-1:0] aw_prod_q;
  logic signed [AWP_W-1:0] aw_prod_d;
  logic signed [AWP_W:0]   aw_rnd;
  logic signed [SUM_W-1:0] aw, vx, vy;
  logic signed [SUM_W-1:0] s_q [NUM_WHEELS];
  logic signed [WP_W-1:0]  wp;
  logic signed [WP_W:0]    wp_rnd;
  logic signed [WHL_W-1:0] w_q [NUM_WHEELS];

  assign aw_prod_d = $signed({1'b0, arm_q}) * vw_q;
  assign aw_rnd    = (AWP_W + 1)'(aw_prod_q) + RND16;
  assign aw        = aw_rnd[AWP_W:16];
  assign vx        = SUM_W'(vx_q);
  assign vy        = SUM_W'(vy_q);
  assign wp        = s_q[cmd_i.lane] * $signed({1'b0, inv_r_q});
  assign wp_rnd    = (WP_W + 1)'(wp) + RND12;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_aw) begin
      aw_prod_q <= aw_prod_d;
    end
    if (cmd_i.calc_sum) begin
      s_q[0] <= -(aw + vx + vy);
      s_q[1] <= -aw + vx - vy;
      s_q[2] <= -aw + vx + vy;
      s_q[3] <= -(aw + vx - vy);
    end
    if (cmd_i.calc_wheel) begin
      w_q[cmd_i.lane] <= wp_rnd[WP_W:12];
    end
  end

  // Largest magnitude and limiter.
  logic [MAG_W-1:0] mag_d [NUM_WHEELS];
  logic [MAG_W-1:0] mag_q [NUM_WHEELS];
  logic [MAG_W-1:0] m01, m23, max_d, max_q;
  logic [DVD_W-1:0] prod_q [NUM_WHEELS];
  logic [DVD_W-1:0] dvd [NUM_WHEELS];
  logic [MAG_W-1:0] rem_q [NUM_WHEELS];
  logic [QUO_W-1:0] dq_q [NUM_WHEELS];
  logic [MAG_W:0]   sh [NUM_WHEELS];
  logic [MAG_W:0]   diff [NUM_WHEELS];
  logic             ge [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag_d[i] = w_q[i][WHL_W-1] ? MAG_W'(-w_q[i]) : MAG_W'(w_q[i]);
      dvd[i]   = prod_q[i] + DVD_W'(max_q >> 1);
      sh[i]    = {rem_q[i], dq_q[i][QUO_W-1]};
      diff[i]  = sh[i] - {1'b0, max_q};
      ge[i]    = (sh[i] >= {1'b0, max_q});
    end
  end

  assign m01   = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
  assign m23   = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
  assign max_d = (m01 > m23) ? m01 : m23;

  assign status_o.need_scale = (max_q > MAG_W'(lim_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_max) begin
      mag_q <= mag_d;
      max_q <= max_d;
    end
    if (cmd_i.scale_prep) begin
      prod_q[cmd_i.lane] <= mag_q[cmd_i.lane] * lim_q;
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (cmd_i.div_init) begin
        rem_q[i] <= dvd[i][DVD_W-1:QUO_W];
        dq_q[i]  <= dvd[i][QUO_W-1:0];
      end else if (cmd_i.div_step) begin
        rem_q[i] <= ge[i] ? diff[i][MAG_W-1:0] : sh[i][MAG_W-1:0];
        dq_q[i]  <= {dq_q[i][QUO_W-2:0], ge[i]};
      end
    end
  end

  // Setpoints and watchdog.
  logic signed [SPEED_WIDTH-1:0] sp_q [NUM_WHEELS];
  logic signed [WHL_W-1:0]       qv [NUM_WHEELS];
  logic [CNT_W-1:0]              idle_q, idle_inc;
  logic                          timed_q;

  assign idle_inc = (idle_q == CNT_MAX) ? idle_q : idle_q + 1'b1;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      qv[i] = $signed(WHL_W'(dq_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        sp_q[i] <= '0;
      end
      idle_q  <= '0;
      timed_q <= 1'b0;
    end else if (cmd_i.commit_plain || cmd_i.commit_scaled) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (cmd_i.commit_scaled) begin
          sp_q[i] <= sat_speed(w_q[i][WHL_W-1] ? -qv[i] : qv[i]);
        end else begin
          sp_q[i] <= sat_speed(w_q[i]);
        end
      end
      idle_q  <= '0;
      timed_q <= 1'b0;
    end else if (cmd_i.tick_update) begin
      idle_q  <= idle_inc;
      timed_q <= (idle_inc > tmo_q);
      if (idle_inc > tmo_q) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          sp_q[i] <= '0;
        end
      end
    end
  end

  // Output register.
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_wh_q [NUM_WHEELS];
  logic                    out_to_q;

  assign status_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        out_wh_q[i] <= OUT_W'(sp_q[i]);
      end
      out_to_q <= timed_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.wheel0_speed = out_wh_q[0];
  assign out_o.wheel1_speed = out_wh_q[1];
  assign out_o.wheel2_speed = out_wh_q[2];
  assign out_o.wheel3_speed = out_wh_q[3];
  assign out_o.timed_out    = out_to_q;

endmodule
